// ===== hdl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, codes and step scripts for the I2C register-access master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Request operation codes
  localparam logic [1:0] REQ_OP_TICK  = 2'd0;
  localparam logic [1:0] REQ_OP_READ  = 2'd1;
  localparam logic [1:0] REQ_OP_WRITE = 2'd2;

  // Configuration register indexes
  localparam logic CFG_TICKS_PER_UNIT = 1'b0;
  localparam logic CFG_CHANNEL_ENABLE = 1'b1;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] channel;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic       sda_sample;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive_enable;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic [2:0] nack_flags;
    logic       rejected;
    logic [2:0] active_channel;
  } res_t;

  // Configuration as seen by the sequencer; enable bits beyond the
  // channel count read as zero.
  typedef struct packed {
    logic [9:0] ticks_per_unit;
    logic [7:0] channel_enable;
  } cfg_t;

  // Sequencer step operations
  typedef enum logic [3:0] {
    OP_D1, OP_D2, OP_SCL_HI, OP_SCL_LO, OP_SDA_HI, OP_SDA_LO,
    OP_SDA_BIT, OP_SDA_REL, OP_ACK, OP_SAMPLE, OP_LOOP, OP_END
  } op_t;

  typedef enum logic [2:0] {
    SCR_START, SCR_SEND, SCR_ACK, SCR_RECV, SCR_STOP
  } scr_t;

  localparam op_t START_SCRIPT [16] = '{
    OP_D1, OP_SDA_HI, OP_SCL_HI, OP_D1, OP_SDA_LO, OP_D2, OP_END, OP_END,
    OP_END, OP_END, OP_END, OP_END, OP_END, OP_END, OP_END, OP_END};
  localparam op_t SEND_SCRIPT [16] = '{
    OP_SCL_LO, OP_D1, OP_SDA_BIT, OP_D1, OP_SCL_HI, OP_D2, OP_SCL_LO, OP_LOOP,
    OP_D1, OP_END, OP_END, OP_END, OP_END, OP_END, OP_END, OP_END};
  localparam op_t ACK_SCRIPT [16] = '{
    OP_SDA_REL, OP_D1, OP_SCL_LO, OP_D1, OP_SCL_HI, OP_D1, OP_ACK, OP_D1,
    OP_SCL_LO, OP_D2, OP_END, OP_END, OP_END, OP_END, OP_END, OP_END};
  localparam op_t RECV_SCRIPT [16] = '{
    OP_D1, OP_SCL_LO, OP_D2, OP_SCL_HI, OP_D1, OP_SAMPLE, OP_D1, OP_LOOP,
    OP_SCL_LO, OP_D1, OP_END, OP_END, OP_END, OP_END, OP_END, OP_END};
  localparam op_t STOP_SCRIPT [16] = '{
    OP_SDA_LO, OP_D1, OP_SCL_HI, OP_D1, OP_SDA_HI, OP_D1, OP_END, OP_END,
    OP_END, OP_END, OP_END, OP_END, OP_END, OP_END, OP_END, OP_END};

  function automatic op_t script_op(input scr_t scr, input logic [3:0] idx);
    case (scr)
      SCR_START: return START_SCRIPT[idx];
      SCR_SEND:  return SEND_SCRIPT[idx];
      SCR_ACK:   return ACK_SCRIPT[idx];
      SCR_RECV:  return RECV_SCRIPT[idx];
      default:   return STOP_SCRIPT[idx];
    endcase
  endfunction

endpackage

// ===== hdl/i2cm_seq.sv =====
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer: runs one script step per tick and handles new requests.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            step_en,
  input  i2cm_pkg::req_t  req,
  input  i2cm_pkg::cfg_t  cfg,
  output i2cm_pkg::res_t  res
);
  import i2cm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START1, PH_DEV, PH_ACK0, PH_REG, PH_ACK1, PH_DATA, PH_ACK2W,
    PH_START2, PH_DEVR, PH_ACKR, PH_RECV, PH_STOP
  } phase_t;

  phase_t      phase, phase_next, nx;
  logic [3:0]  step, step_next;
  logic [2:0]  bit_idx, bit_idx_next;
  logic [9:0]  unit_cnt, unit_cnt_next;
  logic [1:0]  du_left, du_left_next;
  logic [7:0]  shift, shift_next;
  logic [7:0]  dev, dev_next;
  logic [7:0]  regad, regad_next;
  logic [7:0]  wdata, wdata_next;
  logic [2:0]  ch, ch_next;
  logic        is_read, is_read_next;
  logic        scl, scl_next;
  logic        drv, drv_next;
  logic        sda, sda_next;
  logic [2:0]  ack, ack_next;
  logic [7:0]  rx, rx_next;

  scr_t        scr;
  op_t         op;
  logic [9:0]  tpu;
  logic [10:0] uc;
  logic [2:0]  du;
  logic [2:0]  units;
  logic [1:0]  ack_k;
  logic        busy, adv, enter, is_req;
  logic        done_c, rej_c, start_c;

  function automatic phase_t phase_after(input phase_t ph, input logic rd);
    case (ph)
      PH_START1: return PH_DEV;
      PH_DEV:    return PH_ACK0;
      PH_ACK0:   return PH_REG;
      PH_REG:    return PH_ACK1;
      PH_ACK1:   return rd ? PH_START2 : PH_DATA;
      PH_DATA:   return PH_ACK2W;
      PH_ACK2W:  return PH_STOP;
      PH_START2: return PH_DEVR;
      PH_DEVR:   return PH_ACKR;
      PH_ACKR:   return PH_RECV;
      PH_RECV:   return PH_STOP;
      default:   return PH_IDLE;
    endcase
  endfunction

  always_comb begin
    case (phase)
      PH_START1, PH_START2:                 scr = SCR_START;
      PH_DEV, PH_REG, PH_DATA, PH_DEVR:     scr = SCR_SEND;
      PH_ACK0, PH_ACK1, PH_ACK2W, PH_ACKR:  scr = SCR_ACK;
      PH_RECV:                              scr = SCR_RECV;
      default:                              scr = SCR_STOP;
    endcase
    case (phase)
      PH_ACK0: ack_k = 2'd0;
      PH_ACK1: ack_k = 2'd1;
      default: ack_k = 2'd2;
    endcase
  end

  assign op     = script_op(scr, step);
  assign tpu    = (cfg.ticks_per_unit == '0) ? 10'd1 : cfg.ticks_per_unit;
  assign uc     = {1'b0, unit_cnt} + 11'd1;
  assign du     = {1'b0, du_left} + 3'd1;
  assign units  = (op == OP_D2) ? 3'd2 : 3'd1;
  assign busy   = (phase != PH_IDLE);
  assign is_req = (req.operation == REQ_OP_READ) || (req.operation == REQ_OP_WRITE);

  always_comb begin
    phase_next    = phase;
    step_next     = step;
    bit_idx_next  = bit_idx;
    unit_cnt_next = unit_cnt;
    du_left_next  = du_left;
    shift_next    = shift;
    dev_next      = dev;
    regad_next    = regad;
    wdata_next    = wdata;
    ch_next       = ch;
    is_read_next  = is_read;
    scl_next      = scl;
    drv_next      = drv;
    sda_next      = sda;
    ack_next      = ack;
    rx_next       = rx;
    nx            = PH_IDLE;
    adv           = 1'b0;
    enter         = 1'b0;
    done_c        = 1'b0;
    rej_c         = 1'b0;
    start_c       = 1'b0;

    if (busy) begin
      case (op)
        OP_D1, OP_D2: begin
          if (uc >= {1'b0, tpu}) begin
            unit_cnt_next = '0;
            if (du >= units) begin
              du_left_next = '0;
              adv          = 1'b1;
            end else begin
              du_left_next = du[1:0];
            end
          end else begin
            unit_cnt_next = uc[9:0];
          end
        end
        OP_SCL_HI: begin
          scl_next = 1'b1;
          adv      = 1'b1;
        end
        OP_SCL_LO: begin
          scl_next = 1'b0;
          adv      = 1'b1;
        end
        OP_SDA_HI: begin
          drv_next = 1'b1;
          sda_next = 1'b1;
          adv      = 1'b1;
        end
        OP_SDA_LO: begin
          drv_next = 1'b1;
          sda_next = 1'b0;
          adv      = 1'b1;
        end
        OP_SDA_BIT: begin
          drv_next = 1'b1;
          sda_next = shift[3'd7 - bit_idx];
          adv      = 1'b1;
        end
        OP_SDA_REL: begin
          drv_next = 1'b0;
          sda_next = 1'b0;
          adv      = 1'b1;
        end
        OP_ACK: begin
          drv_next = 1'b0;
          sda_next = 1'b0;
          if (req.sda_sample) ack_next[ack_k] = 1'b1;
          adv      = 1'b1;
        end
        OP_SAMPLE: begin
          drv_next   = 1'b0;
          sda_next   = 1'b0;
          shift_next = {shift[6:0], req.sda_sample};
          adv        = 1'b1;
        end
        OP_LOOP: begin
          if (bit_idx != 3'd7) begin
            bit_idx_next = bit_idx + 3'd1;
            step_next    = '0;
          end else begin
            adv = 1'b1;
          end
        end
        default: begin
          // end of script: move to the following phase
          if (phase == PH_RECV) rx_next = shift;
          nx     = phase_after(phase, is_read);
          enter  = 1'b1;
          done_c = (nx == PH_IDLE);
        end
      endcase
      if (adv) step_next = step + 4'd1;
    end

    if (is_req) begin
      if (busy || !cfg.channel_enable[req.channel]) begin
        rej_c = 1'b1;
      end else begin
        dev_next     = req.device_address;
        regad_next   = req.register_address;
        wdata_next   = req.write_data;
        ch_next      = req.channel;
        is_read_next = (req.operation == REQ_OP_READ);
        ack_next     = '0;
        nx           = PH_START1;
        enter        = 1'b1;
        start_c      = 1'b1;
      end
    end

    if (enter) begin
      phase_next    = nx;
      step_next     = '0;
      bit_idx_next  = '0;
      unit_cnt_next = '0;
      du_left_next  = '0;
      case (nx)
        PH_DEV:  shift_next = dev;
        PH_REG:  shift_next = regad;
        PH_DATA: shift_next = wdata;
        PH_DEVR: shift_next = dev | 8'h01;
        PH_RECV: shift_next = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      step     <= '0;
      bit_idx  <= '0;
      unit_cnt <= '0;
      du_left  <= '0;
      ch       <= '0;
      scl      <= 1'b1;
      drv      <= 1'b0;
      sda      <= 1'b0;
      ack      <= '0;
      rx       <= '0;
    end else if (step_en) begin
      phase    <= phase_next;
      step     <= step_next;
      bit_idx  <= bit_idx_next;
      unit_cnt <= unit_cnt_next;
      du_left  <= du_left_next;
      ch       <= ch_next;
      scl      <= scl_next;
      drv      <= drv_next;
      sda      <= sda_next;
      ack      <= ack_next;
      rx       <= rx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      shift   <= shift_next;
      dev     <= dev_next;
      regad   <= regad_next;
      wdata   <= wdata_next;
      is_read <= is_read_next;
    end
  end

  always_comb begin
    res.scl_level        = scl_next;
    res.sda_drive_enable = drv_next;
    res.sda_level        = sda_next;
    res.busy_res         = (phase_next != PH_IDLE);
    res.done_res         = done_c;
    res.read_data        = rx_next;
    res.nack_flags       = ack_next;
    res.rejected         = rej_c;
    res.active_channel   = ch_next;
  end

`ifndef SYNTHESIS
  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    step_en && done_c |=> phase == PH_IDLE)
    else $error("transaction finished but sequencer not idle");

  a_start_enters: assert property (@(posedge clk) disable iff (rst)
    step_en && start_c |=> phase == PH_START1 && ack == 3'd0)
    else $error("accepted request did not start a transaction");

  a_busy_rejects: assert property (@(posedge clk) disable iff (rst)
    step_en && busy && is_req |-> rej_c && !start_c)
    else $error("request while busy was not refused");

  a_released_low: assert property (@(posedge clk) disable iff (rst)
    !drv |-> !sda)
    else $error("SDA level set while line released");
`endif

endmodule

// ===== hdl/i2cm_obuf.sv =====
// ----------------------------------------------------------------------------
// i2cm_obuf
// Two-entry result buffer; lets the sequencer run while the receiver stalls.
// ----------------------------------------------------------------------------
module i2cm_obuf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  i2cm_pkg::res_t  din,
  output logic            room,
  output logic            res_valid,
  input  logic            res_stall,
  output i2cm_pkg::res_t  res
);
  import i2cm_pkg::*;

  res_t       e0, e1;
  logic [1:0] cnt;
  logic       pop;

  assign res_valid = (cnt != 2'd0);
  assign pop       = res_valid && !res_stall;
  assign room      = (cnt != 2'd2) || pop;
  assign res       = e0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cnt)
      2'd0: begin
        if (push) e0 <= din;
      end
      2'd1: begin
        if (push && pop) e0 <= din;
        else if (push) e1 <= din;
      end
      default: begin
        if (pop) begin
          e0 <= e1;
          if (push) e1 <= din;
        end
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("result buffer count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> room)
    else $error("result pushed into full buffer");
`endif

endmodule

// ===== hdl/i2c_master_register_access.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_access
// I2C master for single-register read and write transactions.
// ----------------------------------------------------------------------------
// Usage:
//   Every request on the req channel is one bus timing tick. Its operation
//   field either only advances time, or asks to begin a register read or
//   write on a channel. A tick drives one sequencer step (line change,
//   sample, or one tick of a delay unit of ticks_per_unit ticks).
//   Every request yields exactly one result on the res channel carrying the
//   line levels, busy/done, the last read byte, NACK flags and a refusal bit.
//   Each request passes the input register, then the sequencer into the
//   result buffer. Throughput: one request per cycle while res does not
//   stall; the sequencer state updates in a single pass and results wait
//   in the two-entry result buffer. When res is stalled the buffer fills
//   and req_stall rises; nothing is dropped. Reset leaves SCL high, SDA
//   released, the block idle, all channels disabled, ticks_per_unit at 1.
//   Configuration writes go through cfg_write/cfg_index/cfg_data; the user
//   issues them only while no transaction runs; the block has no check.
// ----------------------------------------------------------------------------
module i2c_master_register_access #(
  parameter int CHANNELS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  i2cm_pkg::req_t  req,
  output logic            res_valid,
  input  logic            res_stall,
  output i2cm_pkg::res_t  res,
  input  logic            cfg_write,
  input  logic            cfg_index,
  input  logic [9:0]      cfg_data
);
  import i2cm_pkg::*;

  // configuration registers
  logic [9:0]          ticks_per_unit;
  logic [CHANNELS-1:0] channel_enable;
  cfg_t                cfg;

  // input register
  req_t req_q;
  logic req_q_valid;
  logic advance;
  logic room;
  res_t seq_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_unit <= 10'd1;
      channel_enable <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TICKS_PER_UNIT: ticks_per_unit <= cfg_data;
        CFG_CHANNEL_ENABLE: channel_enable <= cfg_data[CHANNELS-1:0];
        default: ;
      endcase
    end
  end

  // Enable bits above the channel count stay zero, so channels that do
  // not exist are refused the same way as disabled ones.
  assign cfg.ticks_per_unit = ticks_per_unit;
  assign cfg.channel_enable = 8'(channel_enable);

  // the held request moves on whenever the result buffer can take its result
  assign advance   = req_q_valid && room;
  assign req_stall = req_q_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      req_q_valid <= 1'b1;
    end else if (advance) begin
      req_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) req_q <= req;
  end

  i2cm_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .req     (req_q),
    .cfg     (cfg),
    .res     (seq_res)
  );

  i2cm_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .din       (seq_res),
    .room      (room),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C register-access master. Every request is
// one bus tick. A cycle-level model of the step sequencer predicts the line
// levels and status for each accepted request. A monitor compares every
// accepted result field by field, in order. Directed register reads and
// writes come first, then random traffic under sender idling and receiver
// stalls, then a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import i2cm_pkg::*;

  localparam int CHANNELS     = 8;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_PAD    = 8;
  localparam int RESULT_WAIT  = 20000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RESET_CYCLES = 11;

  // operation code 3 has no meaning; the block treats it as a plain tick
  localparam logic [1:0] REQ_OP_RSVD = 2'd3;

  // Sequencer phases of one transaction
  typedef enum logic [4:0] {
    BUS_IDLE, BUS_START, BUS_DEV, BUS_ACK_DEV, BUS_REG, BUS_ACK_REG, BUS_DATA,
    BUS_ACK_DATA, BUS_RESTART, BUS_DEV_RD, BUS_ACK_RD, BUS_RECV, BUS_STOP
  } bus_phase_e;

  // Step lists per phase kind; everything past the end marker is padding
  localparam op_t START_SEQ [16] = '{
    OP_D1, OP_SDA_HI, OP_SCL_HI, OP_D1, OP_SDA_LO, OP_D2, OP_END, OP_END,
    OP_END, OP_END, OP_END, OP_END, OP_END, OP_END, OP_END, OP_END};
  localparam op_t SEND_SEQ [16] = '{
    OP_SCL_LO, OP_D1, OP_SDA_BIT, OP_D1, OP_SCL_HI, OP_D2, OP_SCL_LO, OP_LOOP,
    OP_D1, OP_END, OP_END, OP_END, OP_END, OP_END, OP_END, OP_END};
  localparam op_t ACK_SEQ [16] = '{
    OP_SDA_REL, OP_D1, OP_SCL_LO, OP_D1, OP_SCL_HI, OP_D1, OP_ACK, OP_D1,
    OP_SCL_LO, OP_D2, OP_END, OP_END, OP_END, OP_END, OP_END, OP_END};
  localparam op_t RECV_SEQ [16] = '{
    OP_D1, OP_SCL_LO, OP_D2, OP_SCL_HI, OP_D1, OP_SAMPLE, OP_D1, OP_LOOP,
    OP_SCL_LO, OP_D1, OP_END, OP_END, OP_END, OP_END, OP_END, OP_END};
  localparam op_t STOP_SEQ [16] = '{
    OP_SDA_LO, OP_D1, OP_SCL_HI, OP_D1, OP_SDA_HI, OP_D1, OP_END, OP_END,
    OP_END, OP_END, OP_END, OP_END, OP_END, OP_END, OP_END, OP_END};

  // --------------------------------------------------------------------------
  // DUT and its ports; every input is known from time zero
  // --------------------------------------------------------------------------
  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  req_t       req       = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  res_t       res;
  logic       cfg_write = 1'b0;
  logic       cfg_index = 1'b0;
  logic [9:0] cfg_data  = '0;

  i2c_master_register_access #(.CHANNELS(CHANNELS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  res_t        bus_snapshots_q[$];   // predicted results, oldest first
  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int          send_idle_pct  = 0;   // chance per cycle that the sender idles
  int          recv_stall_pct = 0;   // chance per cycle that the receiver stalls
  int          hold_token     = 0;   // bumped to ask for one long hold-off
  int          hold_seen      = 0;
  int          hold_left      = 0;

  // Sequencer model state
  bus_phase_e  m_phase;
  logic [3:0]  m_step;
  logic [2:0]  m_bit;
  logic [9:0]  m_unit_cnt;
  logic [1:0]  m_units_done;
  logic [7:0]  m_shift;
  logic [7:0]  m_dev, m_reg, m_data;
  logic [2:0]  m_chan;
  logic        m_is_read;
  logic        m_scl, m_drv, m_sda;
  logic [2:0]  m_nacks;
  logic [7:0]  m_rx;
  logic [9:0]  m_tpu;
  logic [7:0]  m_chan_en;

  // --------------------------------------------------------------------------
  // Sequencer model
  // --------------------------------------------------------------------------
  function automatic void model_reset();
    m_phase = BUS_IDLE;  m_step = '0;  m_bit = '0;  m_unit_cnt = '0;
    m_units_done = '0;  m_shift = '0;
    m_dev = '0;  m_reg = '0;  m_data = '0;  m_chan = '0;  m_is_read = 1'b0;
    m_scl = 1'b1;  m_drv = 1'b0;  m_sda = 1'b0;  // SCL high, SDA released
    m_nacks = '0;  m_rx = '0;
    m_tpu = 10'd1;  m_chan_en = '0;
  endfunction

  function automatic op_t seq_op(input bus_phase_e ph, input logic [3:0] idx);
    case (ph)
      BUS_START, BUS_RESTART:               return START_SEQ[idx];
      BUS_DEV, BUS_REG, BUS_DATA, BUS_DEV_RD: return SEND_SEQ[idx];
      BUS_ACK_DEV, BUS_ACK_REG, BUS_ACK_DATA, BUS_ACK_RD: return ACK_SEQ[idx];
      BUS_RECV:                             return RECV_SEQ[idx];
      default:                              return STOP_SEQ[idx];
    endcase
  endfunction

  function automatic bus_phase_e following_phase(input bus_phase_e ph);
    case (ph)
      BUS_START:    return BUS_DEV;
      BUS_DEV:      return BUS_ACK_DEV;
      BUS_ACK_DEV:  return BUS_REG;
      BUS_REG:      return BUS_ACK_REG;
      BUS_ACK_REG:  return m_is_read ? BUS_RESTART : BUS_DATA;
      BUS_DATA:     return BUS_ACK_DATA;
      BUS_ACK_DATA: return BUS_STOP;
      BUS_RESTART:  return BUS_DEV_RD;
      BUS_DEV_RD:   return BUS_ACK_RD;
      BUS_ACK_RD:   return BUS_RECV;
      BUS_RECV:     return BUS_STOP;
      default:      return BUS_IDLE;
    endcase
  endfunction

  function automatic void begin_phase(input bus_phase_e ph);
    m_phase = ph;
    m_step = '0;
    m_bit = '0;
    m_unit_cnt = '0;
    m_units_done = '0;
    case (ph)
      BUS_DEV:    m_shift = m_dev;
      BUS_REG:    m_shift = m_reg;
      BUS_DATA:   m_shift = m_data;
      BUS_DEV_RD: m_shift = m_dev | 8'h01;  // read address has bit 0 set
      BUS_RECV:   m_shift = '0;
      default:    ;
    endcase
  endfunction

  // One tick of an n-unit delay; the step moves on after n * ticks_per_unit
  function automatic void unit_delay(input logic [1:0] units);
    logic [10:0] cnt;
    logic [2:0]  done_units;
    logic [9:0]  per_unit;
    per_unit = (m_tpu == '0) ? 10'd1 : m_tpu;  // zero counts as one
    cnt = {1'b0, m_unit_cnt} + 11'd1;
    if (cnt >= {1'b0, per_unit}) begin
      m_unit_cnt = '0;
      done_units = {1'b0, m_units_done} + 3'd1;
      if (done_units >= {1'b0, units}) begin
        m_units_done = '0;
        m_step = m_step + 4'd1;
      end else begin
        m_units_done = done_units[1:0];
      end
    end else begin
      m_unit_cnt = cnt[9:0];
    end
  endfunction

  // Runs one sequencer step; returns 1 when the transaction has finished
  function automatic logic run_seq_step(input logic sda);
    op_t        op;
    logic       adv;
    bus_phase_e nx;
    op = seq_op(m_phase, m_step);
    adv = 1'b1;
    case (op)
      OP_D1:      begin unit_delay(2'd1); adv = 1'b0; end
      OP_D2:      begin unit_delay(2'd2); adv = 1'b0; end
      OP_SCL_HI:  m_scl = 1'b1;
      OP_SCL_LO:  m_scl = 1'b0;
      OP_SDA_HI:  begin m_drv = 1'b1; m_sda = 1'b1; end
      OP_SDA_LO:  begin m_drv = 1'b1; m_sda = 1'b0; end
      OP_SDA_BIT: begin m_drv = 1'b1; m_sda = m_shift[3'd7 - m_bit]; end
      OP_SDA_REL: begin m_drv = 1'b0; m_sda = 1'b0; end
      OP_ACK: begin
        m_drv = 1'b0;
        m_sda = 1'b0;
        // slot 0 device address, 1 register, 2 data or read address
        if (sda)
          m_nacks[(m_phase == BUS_ACK_DEV) ? 0 : (m_phase == BUS_ACK_REG) ? 1 : 2] = 1'b1;
      end
      OP_SAMPLE: begin
        m_drv = 1'b0;
        m_sda = 1'b0;
        m_shift = {m_shift[6:0], sda};
      end
      OP_LOOP: begin
        if (m_bit < 3'd7) begin
          m_bit = m_bit + 3'd1;
          m_step = '0;
          adv = 1'b0;
        end
      end
      default: begin
        if (m_phase == BUS_RECV) m_rx = m_shift;
        nx = following_phase(m_phase);
        begin_phase(nx);
        return nx == BUS_IDLE;
      end
    endcase
    if (adv) m_step = m_step + 4'd1;
    return 1'b0;
  endfunction

  // Bus state after one accepted request
  function automatic res_t predict_bus_tick(input req_t r);
    res_t want;
    logic was_busy;
    logic done;
    logic refused;
    was_busy = (m_phase != BUS_IDLE);
    done = 1'b0;
    refused = 1'b0;
    if (was_busy) done = run_seq_step(r.sda_sample);
    if (r.operation == REQ_OP_READ || r.operation == REQ_OP_WRITE) begin
      if (was_busy || int'(r.channel) >= CHANNELS || !m_chan_en[r.channel]) begin
        refused = 1'b1;
      end else begin
        // accepting tick only latches; first step runs on the next tick
        m_dev = r.device_address;
        m_reg = r.register_address;
        m_data = r.write_data;
        m_chan = r.channel;
        m_is_read = (r.operation == REQ_OP_READ);
        m_nacks = '0;
        begin_phase(BUS_START);
      end
    end
    want.scl_level        = m_scl;
    want.sda_drive_enable = m_drv;
    want.sda_level        = m_sda;
    want.busy_res         = (m_phase != BUS_IDLE);
    want.done_res         = done;
    want.read_data        = m_rx;
    want.nack_flags       = m_nacks;
    want.rejected         = refused;
    want.active_channel   = m_chan;
    return want;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off when hold_token moves
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each accepted result with the oldest prediction
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (bus_snapshots_q.size() == 0) begin
        note_mismatch("result with nothing pending", '0, 32'(res));
      end else begin
        want = bus_snapshots_q.pop_front();
        if (res.scl_level !== want.scl_level)
          note_mismatch("scl_level", want.scl_level, res.scl_level);
        if (res.sda_drive_enable !== want.sda_drive_enable)
          note_mismatch("sda_drive_enable", want.sda_drive_enable, res.sda_drive_enable);
        if (res.sda_level !== want.sda_level)
          note_mismatch("sda_level", want.sda_level, res.sda_level);
        if (res.busy_res !== want.busy_res)
          note_mismatch("busy_res", want.busy_res, res.busy_res);
        if (res.done_res !== want.done_res)
          note_mismatch("done_res", want.done_res, res.done_res);
        if (res.read_data !== want.read_data)
          note_mismatch("read_data", want.read_data, res.read_data);
        if (res.nack_flags !== want.nack_flags)
          note_mismatch("nack_flags", want.nack_flags, res.nack_flags);
        if (res.rejected !== want.rejected)
          note_mismatch("rejected", want.rejected, res.rejected);
        if (res.active_channel !== want.active_channel)
          note_mismatch("active_channel", want.active_channel, res.active_channel);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL i2c_master_register_access");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request side helpers
  // --------------------------------------------------------------------------
  function automatic req_t random_req(input logic [1:0] op, input int high_pct);
    req_t r;
    r.operation        = op;
    r.channel          = $urandom_range(7);
    r.device_address   = $urandom_range(255);
    r.register_address = $urandom_range(255);
    r.write_data       = $urandom_range(255);
    r.sda_sample       = ($urandom_range(99) < high_pct);
    return r;
  endfunction

  function automatic req_t bus_req(input logic [1:0] op, input logic [2:0] ch,
                                   input logic [7:0] dev, input logic [7:0] regi,
                                   input logic [7:0] data, input logic sda);
    req_t r;
    r.operation        = op;
    r.channel          = ch;
    r.device_address   = dev;
    r.register_address = regi;
    r.write_data       = data;
    r.sda_sample       = sda;
    return r;
  endfunction

  // Offer one request, hold it until taken, then record its prediction.
  // Valid stays high after acceptance; the next call decides whether to idle.
  task automatic send_req(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    bus_snapshots_q.push_back(predict_bus_tick(r));
  endtask

  // Tick until the running transaction ends, then drain every result and
  // wait out the DRAIN_PAD padding before anything else happens
  task automatic settle(input int high_pct);
    int n;
    while (m_phase != BUS_IDLE) send_req(random_req(REQ_OP_TICK, high_pct));
    req_valid <= 1'b0;
    for (n = 0; n < RESULT_WAIT && bus_snapshots_q.size() != 0; n++) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Only called with the block idle and nothing pending
  task automatic write_cfg(input logic idx, input logic [9:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_TICKS_PER_UNIT) m_tpu = value;
    else m_chan_en = value[7:0];
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // All channels off: both request kinds are refused; code 3 is just a tick
  task automatic test_after_reset();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_cfg(CFG_TICKS_PER_UNIT, 10'd1);
    write_cfg(CFG_CHANNEL_ENABLE, 10'h000);
    send_req(bus_req(REQ_OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_req(bus_req(REQ_OP_RSVD, 3'd7, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_req(bus_req(REQ_OP_READ, 3'd0, 8'hA0, 8'h10, 8'h00, 1'b0));
    send_req(bus_req(REQ_OP_WRITE, 3'd7, 8'hA0, 8'h10, 8'h55, 1'b1));
    settle(50);
  endtask

  // Writes with a zero unit setting (runs as one tick per unit);
  // one run with every acknowledge missed, one with all acknowledged, then a mixed one
  task automatic test_write_path();
    write_cfg(CFG_TICKS_PER_UNIT, 10'd0);
    write_cfg(CFG_CHANNEL_ENABLE, 10'h0FF);
    send_req(bus_req(REQ_OP_WRITE, 3'd7, 8'hFF, 8'h00, 8'hFF, 1'b0));
    // refused because busy, but this tick still runs the first step
    send_req(bus_req(REQ_OP_READ, 3'd0, 8'h12, 8'h34, 8'h56, 1'b1));
    settle(100);
    send_req(bus_req(REQ_OP_WRITE, 3'd3, 8'h00, 8'hFF, 8'h00, 1'b1));
    settle(0);
    send_req(bus_req(REQ_OP_WRITE, 3'd1, 8'hA5, 8'h5A, 8'hC3, 1'b0));
    settle(50);
  endtask

  // Reads: all-ones and all-zeros received bytes, then a mixed one
  task automatic test_read_path();
    write_cfg(CFG_TICKS_PER_UNIT, 10'd2);
    send_req(bus_req(REQ_OP_READ, 3'd0, 8'h00, 8'hFF, 8'h00, 1'b0));
    settle(100);
    send_req(bus_req(REQ_OP_READ, 3'd5, 8'hFE, 8'h81, 8'hFF, 1'b1));
    send_req(bus_req(REQ_OP_WRITE, 3'd5, 8'h00, 8'h00, 8'h00, 1'b0));
    settle(0);
    send_req(bus_req(REQ_OP_READ, 3'd2, 8'h3C, 8'h7E, 8'h00, 1'b0));
    settle(50);
  endtask

  // Widest delay unit: a single write, no idling, to keep the run short
  task automatic test_slow_units();
    write_cfg(CFG_TICKS_PER_UNIT, 10'd1023);
    write_cfg(CFG_CHANNEL_ENABLE, 10'h080);
    send_req(bus_req(REQ_OP_WRITE, 3'd6, 8'hA6, 8'h3C, 8'h5A, 1'b0));  // disabled
    send_req(bus_req(REQ_OP_WRITE, 3'd7, 8'hA6, 8'h3C, 8'h5A, 1'b1));
    settle(50);
  endtask

  // Random traffic: transactions run to completion with random SDA, mixed
  // with refused requests and code-3 ticks as noise
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_items);
    req_t r;
    int   pick;
    int   i;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    write_cfg(CFG_TICKS_PER_UNIT, 10'($urandom_range(1, 3)));
    write_cfg(CFG_CHANNEL_ENABLE, 10'($urandom_range(1, 255)));
    for (i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      r = random_req(REQ_OP_TICK, 50);
      if (m_phase == BUS_IDLE) begin
        if (pick < 40) begin
          r.operation = ($urandom_range(1) != 0) ? REQ_OP_READ : REQ_OP_WRITE;
          // mostly aim at an enabled channel, sometimes at a disabled one
          while (!m_chan_en[r.channel] && $urandom_range(3) != 0)
            r.channel = $urandom_range(7);
        end else if (pick < 45) begin
          r.operation = REQ_OP_RSVD;
        end
      end else if (pick < 4) begin
        r.operation = ($urandom_range(1) != 0) ? REQ_OP_READ : REQ_OP_WRITE;
      end else if (pick < 7) begin
        r.operation = REQ_OP_RSVD;
      end
      send_req(r);
    end
    settle(50);
  endtask

  // Receiver holds off long enough for the block to fill and stall its
  // input while the sender keeps offering; then the sender waits for all
  task automatic test_backpressure();
    int i;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_cfg(CFG_TICKS_PER_UNIT, 10'd1);
    write_cfg(CFG_CHANNEL_ENABLE, 10'h3FF);  // bits above the channels drop
    hold_token <= hold_token + 1;
    send_req(random_req(REQ_OP_WRITE, 50));
    for (i = 0; i < 150; i++) send_req(random_req(REQ_OP_TICK, 50));
    settle(50);
    send_req(random_req(REQ_OP_READ, 50));
    settle(50);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    model_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_write_path();
    test_read_path();
    test_slow_units();
    test_random_traffic(0, 0, 200);
    test_random_traffic(73, 0, 200);
    test_random_traffic(0, 73, 200);
    test_random_traffic(20, 20, 200);
    test_backpressure();

    // anything still pending after the drain counts against the run
    mismatch_count += bus_snapshots_q.size();
    if (mismatch_count == 0) begin
      $display("PASS i2c_master_register_access");
    end else begin
      $display("FAIL i2c_master_register_access");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/i2cm_pkg.sv
hdl/i2cm_seq.sv
hdl/i2cm_obuf.sv
hdl/i2c_master_register_access.sv
dv/testbench.sv
